// ----- design/hsv_light_to_led_bytes_unit_defines.svh -----
// Assertion helpers shared by the light color unit.
// Both macros sample on clk and are disabled during rst.
`ifndef HSV_LIGHT_TO_LED_BYTES_UNIT_DEFINES_SVH
`define HSV_LIGHT_TO_LED_BYTES_UNIT_DEFINES_SVH

// Condition holds at every edge out of reset.
`define HSVL_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define HSVL_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- design/hsvl_pkg.sv -----
package hsvl_pkg;

  localparam int SCALE = 254;

  // attribute selector carried with each input word
  typedef enum logic [1:0] {
    KIND_ON    = 2'd0,
    KIND_LEVEL = 2'd1,
    KIND_HUE   = 2'd2,
    KIND_SAT   = 2'd3
  } kind_t;

  localparam logic [7:0] LEVEL_RESET = 8'd128;
  localparam logic [7:0] HUE_RESET   = 8'd21;
  localparam logic [7:0] SAT_RESET   = 8'd254;

  // snapshot of the light attributes handed from front to back
  typedef struct packed {
    logic       on;
    logic [7:0] level;
    logic [7:0] hue;
    logic [7:0] sat;
  } job_t;

  typedef struct packed {
    logic not_empty;
    logic not_full;
  } q_status_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    B_IDLE,
    B_HUE,
    B_TERM,
    B_MIX,
    B_SCALE,
    B_BIAS,
    B_DIV,
    B_DONE
  } back_state_t;

  // datapath widths
  localparam int LANES    = 4;
  localparam int K_W      = 18;   // per-channel weight, range -254..64770
  localparam int N_W      = 26;   // level * weight
  localparam int A_W      = 34;   // 255*N + DEN/2
  localparam int X_W      = 29;   // (255*N + DEN/2) / 8, below 2^29
  localparam int R_W      = 30;   // reciprocal of 127^3
  localparam int RECIP_SH = 50;   // 29 numerator bits + 21 divisor bits
  localparam int P_W      = X_W + R_W;
  localparam int Q_W      = P_W - RECIP_SH;   // quotient bits before clamp

  localparam logic [63:0] DEN_64     = 64'(SCALE) * 64'(SCALE) * 64'(SCALE);
  localparam logic [63:0] DEN_ODD_64 = DEN_64 >> 3;   // 127^3

  localparam logic signed [K_W-1:0] KC     = K_W'(SCALE * SCALE);
  localparam logic signed [A_W-1:0] A_BIAS = A_W'(DEN_64 >> 1);
  localparam logic signed [A_W-1:0] A_MULT = A_W'(255);
  localparam logic [R_W-1:0]        RECIP  =
    R_W'(((64'd1 << RECIP_SH) + DEN_ODD_64 - 64'd1) / DEN_ODD_64);
  localparam logic [10:0]           POS_WRAP = 11'(6 * SCALE);

endpackage

// ----- design/hsvl_queue.sv -----
`include "hsv_light_to_led_bytes_unit_defines.svh"

module hsvl_queue
  import hsvl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      head,
  output q_status_t status
);

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= QPTR_W'((32'(wr_ptr) + 1) % QUEUE_DEPTH);
      end
      if (pop) begin
        rd_ptr <= QPTR_W'((32'(rd_ptr) + 1) % QUEUE_DEPTH);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  assign head             = entries[rd_ptr];
  assign status.not_empty = (count != '0);
  assign status.not_full  = (count != QCNT_W'(QUEUE_DEPTH));

  `HSVL_ASSERT_ALWAYS(a_count_bound, count <= QCNT_W'(QUEUE_DEPTH), "queue count past depth")
  `HSVL_ASSERT_IMPLIES(a_no_overflow, push && !pop, count != QCNT_W'(QUEUE_DEPTH), "queue overflow")
  `HSVL_ASSERT_IMPLIES(a_no_underflow, pop, count != '0, "queue underflow")

endmodule

// ----- design/hsvl_front.sv -----
module hsvl_front
  import hsvl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [7:0] value,
  input  q_status_t  q_status,
  output logic       push,
  output job_t       push_job
);

  logic       is_on;
  logic [7:0] level_value;
  logic [7:0] hue_value;
  logic [7:0] saturation_value;

  logic       accept;
  logic       drop;
  job_t       job_next;

  assign in_ready = q_status.not_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    job_next.on    = is_on;
    job_next.level = level_value;
    job_next.hue   = hue_value;
    job_next.sat   = saturation_value;
    drop           = 1'b0;
    unique case (kind_t'(kind))
      KIND_ON:    job_next.on  = (value != 8'd0);
      KIND_LEVEL: begin
        // level of zero leaves the light alone and yields no word
        if (value == 8'd0) begin
          drop = 1'b1;
        end else begin
          job_next.level = value;
        end
      end
      KIND_HUE:   job_next.hue = value;
      KIND_SAT:   job_next.sat = value;
      default:    drop = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_on            <= 1'b0;
      level_value      <= LEVEL_RESET;
      hue_value        <= HUE_RESET;
      saturation_value <= SAT_RESET;
    end else if (accept) begin
      is_on            <= job_next.on;
      level_value      <= job_next.level;
      hue_value        <= job_next.hue;
      saturation_value <= job_next.sat;
    end
  end

  assign push     = accept && !drop;
  assign push_job = job_next;

endmodule

// ----- design/hsvl_back.sv -----
`include "hsv_light_to_led_bytes_unit_defines.svh"

module hsvl_back
  import hsvl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  q_status_t  q_status,
  input  job_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] byte_first,
  output logic [7:0] byte_second,
  output logic [7:0] byte_third,
  output logic [7:0] byte_fourth
);

  back_state_t state;
  back_state_t state_next;

  logic chip_type;

  // hue stage
  logic [2:0] sector;
  logic [7:0] tval;
  logic [10:0] pos_raw;
  logic [10:0] pos_c;
  logic [2:0]  sector_c;
  logic [10:0] frac_c;
  logic [7:0]  tval_c;

  // weight stage
  logic signed [K_W-1:0] k0;
  logic signed [K_W-1:0] kx;
  logic signed [9:0]     sat_diff;
  logic [15:0]           sat_t;
  logic signed [K_W-1:0] k0_c;
  logic signed [K_W-1:0] kx_c;

  // lanes in wire byte order
  logic signed [K_W-1:0] lane_k   [LANES];
  logic signed [K_W-1:0] lane_k_c [LANES];
  logic signed [K_W-1:0] ch_r;
  logic signed [K_W-1:0] ch_g;
  logic signed [K_W-1:0] ch_b;
  logic signed [K_W-1:0] ch_w;
  logic signed [N_W-1:0] lane_n   [LANES];
  logic signed [A_W-1:0] lane_a_c [LANES];
  logic [X_W-1:0]        lane_x   [LANES];
  logic [P_W-1:0]        lane_p_c [LANES];
  logic [Q_W-1:0]        quo      [LANES];
  logic [7:0]            lane_byte [LANES];
  logic                  load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      chip_type <= 1'b0;
    end else if (cfg_we) begin
      chip_type <= cfg_wdata;
    end
  end

  // sector position: hue*6 over 254, wrapping past six sectors
  always_comb begin
    pos_raw = 11'(head.hue) * 11'd6;
    pos_c   = (pos_raw >= POS_WRAP) ? pos_raw - POS_WRAP : pos_raw;
    priority if (pos_c >= 11'(5 * SCALE)) sector_c = 3'd5;
    else if (pos_c >= 11'(4 * SCALE))     sector_c = 3'd4;
    else if (pos_c >= 11'(3 * SCALE))     sector_c = 3'd3;
    else if (pos_c >= 11'(2 * SCALE))     sector_c = 3'd2;
    else if (pos_c >= 11'(SCALE))         sector_c = 3'd1;
    else                                  sector_c = 3'd0;
    frac_c = pos_c - 11'(sector_c) * 11'(SCALE);
    tval_c = sector_c[0] ? 8'(SCALE) - frac_c[7:0] : frac_c[7:0];
  end

  // weights: m = 254*(254-s), x = s*t + m, c + m = 254*254
  always_comb begin
    sat_diff = 10'sd254 - $signed({2'b00, head.sat});
    k0_c     = K_W'(sat_diff) * $signed(K_W'(SCALE));
    sat_t    = 16'(head.sat) * 16'(tval);
    kx_c     = $signed(K_W'(sat_t)) + k0_c;
  end

  always_comb begin
    unique case (sector)
      3'd0:    begin ch_r = KC; ch_g = kx; ch_b = k0; end
      3'd1:    begin ch_r = kx; ch_g = KC; ch_b = k0; end
      3'd2:    begin ch_r = k0; ch_g = KC; ch_b = kx; end
      3'd3:    begin ch_r = k0; ch_g = kx; ch_b = KC; end
      3'd4:    begin ch_r = kx; ch_g = k0; ch_b = KC; end
      default: begin ch_r = KC; ch_g = k0; ch_b = kx; end
    endcase
    ch_w = ch_r;
    if (ch_g < ch_w) ch_w = ch_g;
    if (ch_b < ch_w) ch_w = ch_b;
    if (!head.on) begin
      for (int i = 0; i < LANES; i++) lane_k_c[i] = '0;
    end else if (chip_type) begin
      lane_k_c[0] = ch_r - ch_w;
      lane_k_c[1] = ch_g - ch_w;
      lane_k_c[2] = ch_b - ch_w;
      lane_k_c[3] = ch_w;
    end else begin
      lane_k_c[0] = ch_g;
      lane_k_c[1] = ch_r;
      lane_k_c[2] = ch_b;
      lane_k_c[3] = '0;
    end
  end

  // rounding divide by 254^3: the bias step drops the factor 8, the
  // reciprocal multiply is exact for 127^3 over every numerator below 2^29
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lane_a_c[i]  = A_W'(lane_n[i]) * A_MULT + A_BIAS;
      lane_p_c[i]  = P_W'(lane_x[i]) * P_W'(RECIP);
      lane_byte[i] = quo[i][Q_W-1] ? 8'hFF : quo[i][7:0];
    end
  end

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    unique case (state)
      B_IDLE:  if (q_status.not_empty) state_next = B_HUE;
      B_HUE:   state_next = B_TERM;
      B_TERM:  state_next = B_MIX;
      B_MIX:   state_next = B_SCALE;
      B_SCALE: state_next = B_BIAS;
      B_BIAS:  state_next = B_DIV;
      B_DIV:   state_next = B_DONE;
      B_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  assign pop = load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_HUE: begin
        sector <= sector_c;
        tval   <= tval_c;
      end
      B_TERM: begin
        k0 <= k0_c;
        kx <= kx_c;
      end
      B_MIX: begin
        for (int i = 0; i < LANES; i++) lane_k[i] <= lane_k_c[i];
      end
      B_SCALE: begin
        for (int i = 0; i < LANES; i++) begin
          lane_n[i] <= N_W'($signed({1'b0, head.level})) * N_W'(lane_k[i]);
        end
      end
      B_BIAS: begin
        // negative numerators round to zero
        for (int i = 0; i < LANES; i++) begin
          lane_x[i] <= lane_a_c[i][A_W-1] ? '0 : lane_a_c[i][X_W+2:3];
        end
      end
      B_DIV: begin
        for (int i = 0; i < LANES; i++) quo[i] <= lane_p_c[i][P_W-1:RECIP_SH];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      byte_first  <= lane_byte[0];
      byte_second <= lane_byte[1];
      byte_third  <= lane_byte[2];
      byte_fourth <= lane_byte[3];
    end
  end

  `HSVL_ASSERT_IMPLIES(a_div_order, state == B_DIV, $past(state) == B_BIAS, "divide step out of order")
  `HSVL_ASSERT_IMPLIES(a_off_dark, state == B_DONE && !head.on, lane_byte[0] == 8'd0, "dark pixel not zero")
  `HSVL_ASSERT_IMPLIES(a_load_src, $rose(out_valid), $past(state == B_DONE), "result without finished job")

endmodule

// ----- design/hsv_light_to_led_bytes_unit.sv -----
// Light color unit: keeps on/off, level, hue and saturation of one light and
// turns each pushed attribute word into the wire bytes of one LED pixel.
// Input channel (in_valid/in_ready, kind, value): one attribute write per
// word. A level write of zero updates nothing and yields no output word.
// Output channel (out_valid/out_ready, byte_first..byte_fourth): one pixel
// word per pushed attribute word, in arrival order. Mode 0 gives G,R,B and
// a zero fourth byte; mode 1 gives R-W,G-W,B-W, then white W = min(r,g,b).
// cfg_we/cfg_wdata write the mode bit; write it only while the unit is idle.
// The back-end sequencer works on one word at a time: idle check, five setup
// states, one reciprocal-multiply divide and the load, which waits while a
// result is still held on the output.
// A two-word queue sits between front and back, so inputs are still taken
// while a result waits on out_ready; in_ready drops when the queue is full.
// Reset (rst, synchronous): light off, level 128, hue 21, saturation 254,
// mode 0, queue empty, no output pending.
`include "hsv_light_to_led_bytes_unit_defines.svh"

module hsv_light_to_led_bytes_unit
  import hsvl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [7:0] value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] byte_first,
  output logic [7:0] byte_second,
  output logic [7:0] byte_third,
  output logic [7:0] byte_fourth
);

  q_status_t q_status;
  logic      push;
  logic      pop;
  job_t      push_job;
  job_t      head;

  // front: attribute registers, drop of zero-level writes
  hsvl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .value    (value),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  // attribute snapshots waiting for the color engine
  hsvl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // back: sector/weight math, scale, rounding divide, output register
  hsvl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .q_status    (q_status),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .byte_first  (byte_first),
    .byte_second (byte_second),
    .byte_third  (byte_third),
    .byte_fourth (byte_fourth)
  );

  `HSVL_ASSERT_IMPLIES(a_pop_has_data, pop, q_status.not_empty, "pop from empty queue")
  `HSVL_ASSERT_IMPLIES(a_push_has_room, push, in_ready, "push without room")
  `HSVL_ASSERT_IMPLIES(a_pop_frees, pop && !out_ready, !out_valid, "result overwritten")

endmodule
